/* rtl/pfr_pkg.sv */
package pfr_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CMP_READ,
        ST_CMP_EVAL,
        ST_PEEL_READ,
        ST_PEEL_EVAL,
        ST_EMIT_READ,
        ST_EMIT
    } pfr_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic store_item;
        logic set_overflow;
        logic clear_run;
        logic start_sort;
        logic cmp_step;
        logic peel_step;
        logic emit_step;
        logic emit_load;
    } pfr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic cmp_done;
        logic peel_done;
        logic emit_last;
    } pfr_status_t;

endpackage

/* rtl/pfr_ctrl.sv */
module pfr_ctrl
    import pfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_final,
    output logic        in_ready,
    input  logic        out_free,
    input  pfr_status_t status,
    output pfr_cmd_t    cmd
);

    pfr_state_t state_reg;
    pfr_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store_item   = !status.full;
                    cmd.set_overflow = status.full;
                    if (in_final)
                    begin
                        cmd.start_sort = 1'b1;
                        state_next     = ST_CMP_READ;
                    end
                end
            end
            ST_CMP_READ:
            begin
                state_next = ST_CMP_EVAL;
            end
            ST_CMP_EVAL:
            begin
                cmd.cmp_step = 1'b1;
                state_next   = status.cmp_done ? ST_PEEL_READ : ST_CMP_READ;
            end
            // Each front is one pass over the dominance rows
            ST_PEEL_READ:
            begin
                if (status.peel_done)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = ST_EMIT_READ;
                end
                else
                begin
                    state_next = ST_PEEL_EVAL;
                end
            end
            ST_PEEL_EVAL:
            begin
                cmd.peel_step = 1'b1;
                state_next    = ST_PEEL_READ;
            end
            ST_EMIT_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit_step = 1'b1;
                    if (status.emit_last)
                    begin
                        cmd.clear_run = 1'b1;
                        state_next    = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_EMIT_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !in_ready)
        else $error("input accepted while sorting");
    a_sort_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && in_valid && in_final) |=> (state_reg == ST_CMP_READ))
        else $error("final item did not start sort");
    a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_run |=> (state_reg == ST_LOAD))
        else $error("run end did not return to load");
`endif

endmodule

/* rtl/pfr_datapath.sv */
module pfr_datapath
    import pfr_pkg::*;
#(
    parameter int MAX_POP = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] energy_value,
    input  logic [31:0] cost_value,
    input  logic [31:0] time_value,
    input  pfr_cmd_t    cmd,
    output pfr_status_t status,
    output logic [5:0]  res_index,
    output logic [6:0]  res_rank,
    output logic        res_overflow,
    output logic        res_last
);

    localparam int IW = (MAX_POP > 1) ? $clog2(MAX_POP) : 1;
    localparam int CW = $clog2(MAX_POP + 1);

    // Objective memories
    logic [95:0] obj_mem [MAX_POP];
    logic [95:0] p_obj_reg;
    logic [95:0] q_obj_reg;

    logic [CW-1:0] count_reg;
    logic          overflow_reg;
    logic [IW-1:0] p_reg;
    logic [IW-1:0] q_reg;

    // Dominance rows: bit q of dom_mem[p] is set when p beats q
    logic [MAX_POP-1:0] dom_mem [MAX_POP];
    logic [MAX_POP-1:0] dom_rd_reg;
    logic [MAX_POP-1:0] row_reg;
    logic [MAX_POP-1:0] row_next;
    logic [MAX_POP-1:0] hit_reg;
    logic [MAX_POP-1:0] hit_next;
    logic [MAX_POP-1:0] alive_reg;
    logic [6:0]         rank_mem [MAX_POP];
    logic [6:0]         rank_rd_reg;
    logic [6:0]         cur_rank_reg;
    logic [IW-1:0]      emit_reg;

    logic [IW-1:0] wr_addr;
    logic [IW-1:0] last_idx;
    assign wr_addr  = count_reg[IW-1:0];
    assign last_idx = IW'(count_reg - CW'(1));

    // Memory write and operand reads
    always_ff @(posedge clk)
    begin
        if (cmd.store_item)
        begin
            obj_mem[wr_addr] <= {time_value, cost_value, energy_value};
        end
        p_obj_reg <= obj_mem[p_reg];
        q_obj_reg <= obj_mem[q_reg];
    end

    // Pair compare
    logic p_le;
    logic q_le;
    logic p_beats;
    always_comb
    begin
        p_le = (p_obj_reg[31:0] <= q_obj_reg[31:0]) && (p_obj_reg[63:32] <= q_obj_reg[63:32])
            && (p_obj_reg[95:64] <= q_obj_reg[95:64]);
        q_le = (q_obj_reg[31:0] <= p_obj_reg[31:0]) && (q_obj_reg[63:32] <= p_obj_reg[63:32])
            && (q_obj_reg[95:64] <= p_obj_reg[95:64]);
        p_beats = p_le && !q_le;
    end

    // Row being built for p, and solutions hit by an alive dominator this pass
    always_comb
    begin
        row_next        = row_reg;
        row_next[q_reg] = p_beats;
        hit_next        = hit_reg;
        if (alive_reg[p_reg])
        begin
            hit_next = hit_reg | dom_rd_reg;
        end
    end

    // Dominance row store
    always_ff @(posedge clk)
    begin
        if (cmd.cmp_step && (q_reg == last_idx))
        begin
            dom_mem[p_reg] <= row_next;
        end
        dom_rd_reg <= dom_mem[p_reg];
    end

    // Rank store: every pass writes its alive solutions, the last write wins
    always_ff @(posedge clk)
    begin
        if (cmd.peel_step && alive_reg[p_reg])
        begin
            rank_mem[p_reg] <= cur_rank_reg;
        end
        rank_rd_reg <= rank_mem[emit_reg];
    end

    assign status.full      = (count_reg == CW'(MAX_POP));
    assign status.cmp_done  = (p_reg == last_idx) && (q_reg == last_idx);
    assign status.peel_done = (alive_reg == '0);
    assign status.emit_last = (emit_reg == last_idx);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            p_reg        <= '0;
            q_reg        <= '0;
            row_reg      <= '0;
            hit_reg      <= '0;
            alive_reg    <= '0;
            cur_rank_reg <= 7'd1;
            emit_reg     <= '0;
        end
        else
        begin
            if (cmd.store_item)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.set_overflow)
            begin
                overflow_reg <= 1'b1;
            end
            if (cmd.start_sort)
            begin
                p_reg        <= '0;
                q_reg        <= '0;
                row_reg      <= '0;
                hit_reg      <= '0;
                cur_rank_reg <= 7'd1;
            end
            if (cmd.cmp_step)
            begin
                if (status.cmp_done)
                begin
                    p_reg   <= '0;
                    q_reg   <= '0;
                    row_reg <= '0;
                    for (int k = 0; k < MAX_POP; k++)
                    begin
                        alive_reg[k] <= (k < count_reg);
                    end
                end
                else if (q_reg == last_idx)
                begin
                    q_reg   <= '0;
                    p_reg   <= p_reg + IW'(1);
                    row_reg <= '0;
                end
                else
                begin
                    q_reg   <= q_reg + IW'(1);
                    row_reg <= row_next;
                end
            end
            if (cmd.peel_step)
            begin
                if (p_reg == last_idx)
                begin
                    p_reg        <= '0;
                    hit_reg      <= '0;
                    alive_reg    <= alive_reg & hit_next;
                    cur_rank_reg <= cur_rank_reg + 7'd1;
                end
                else
                begin
                    p_reg   <= p_reg + IW'(1);
                    hit_reg <= hit_next;
                end
            end
            if (cmd.emit_load)
            begin
                emit_reg <= '0;
            end
            else if (cmd.emit_step)
            begin
                emit_reg <= emit_reg + IW'(1);
            end
            if (cmd.clear_run)
            begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
        end
    end

    assign res_index    = 6'(emit_reg);
    assign res_rank     = rank_rd_reg;
    assign res_overflow = overflow_reg;
    assign res_last     = status.emit_last;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POP))
        else $error("load count beyond capacity");
    a_peel_alive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.peel_step |-> (alive_reg != '0))
        else $error("front pass with no solution left");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_run |=> (count_reg == '0 && !overflow_reg))
        else $error("run state not cleared");
`endif

endmodule

/* rtl/pareto_front_ranker.sv */
// Pareto front ranker, three minimized objectives, up to MAX_POP solutions.
// Loading: one transaction per cycle. After the final item the pair compare
// does one memory read and one compare per ordered pair, then each front is a read
// and evaluate pass over all n rows, with one end check, then n results, each read then sent.
// Input is stalled from the final item until the last result enters the output register.
// rst_n clears the load count, overflow flag and controller; stores need no reset.
module pareto_front_ranker
    import pfr_pkg::*;
#(
    parameter int MAX_POP = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,  // energy_value, cost_value, time_value
    input  logic         s_tlast,  // final_item
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,  // solution_index, front_rank, overflow_seen, zero pad
    output logic         m_tlast   // last_result
);

    pfr_cmd_t    cmd;
    pfr_status_t status;
    logic [5:0]  res_index;
    logic [6:0]  res_rank;
    logic        res_overflow;
    logic        res_last;
    logic        out_free;
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic        m_tlast_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    pfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_final (s_tlast),
        .in_ready (s_tready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    pfr_datapath #(.MAX_POP(MAX_POP)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .energy_value (s_tdata[31:0]),
        .cost_value   (s_tdata[63:32]),
        .time_value   (s_tdata[95:64]),
        .cmd          (cmd),
        .status       (status),
        .res_index    (res_index),
        .res_rank     (res_rank),
        .res_overflow (res_overflow),
        .res_last     (res_last)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_tvalid_reg <= cmd.emit_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && cmd.emit_step)
        begin
            m_tdata_reg <= {2'b00, res_overflow, res_rank, res_index};
            m_tlast_reg <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
